FILE: hdl/date_string_validator_assert.svh
// Assertion macros used by the checker of the date string validator.
// Standalone header; the including file supplies clock and reset names.
`ifndef DATE_STRING_VALIDATOR_ASSERT_SVH
`define DATE_STRING_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DSV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/dsv_pkg.sv
// Shared types, constants and helper functions of the date string validator.
// No dependencies; all other files but the assertion header refer to it.
`timescale 1ns / 1ps

package dsv_pkg;

   localparam int VAL_W      = 31;
   localparam int CHAR_W     = 8;
   localparam int CNT_W      = 4;
   localparam int DAY_W      = 5;
   localparam int MOD_W      = 5;
   localparam int DIG_W      = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int PARTS      = 3;

   localparam logic [CNT_W-1:0]  CNT_MAX    = 4'd15;
   localparam logic [CNT_W-1:0]  CNT_DATE   = 4'd3;
   localparam logic [VAL_W-1:0]  DAY_LIMIT  = 31'd31;
   localparam logic [VAL_W-1:0]  MONTH_MAX  = 31'd12;
   localparam logic [VAL_W-1:0]  YEAR_MIN_RST = 31'd1900;
   localparam logic [VAL_W-1:0]  YEAR_MAX_RST = 31'd2100;
   localparam logic [MOD_W:0]    MOD_BASE   = 6'd25;
   localparam logic [DAY_W-1:0]  FEB_LEAP   = 5'd29;
   localparam logic [DIG_W-1:0]  FEB        = 4'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

   localparam logic [DAY_W-1:0] MONTH_LEN [13] =
      '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   typedef logic [VAL_W-1:0] val_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_PART_COUNT = 3'd1,
      ERR_MONTH      = 3'd2,
      ERR_DAY        = 3'd3,
      ERR_YEAR       = 3'd4
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YEAR_MIN = 1'b0,
      CSR_YEAR_MAX = 1'b1
   } csr_idx_type;

   // A stored part keeps its value and its residue modulo 25, which the
   // leap-year test needs for the century rules.
   typedef struct packed {
      val_type           value;
      logic [MOD_W-1:0]  mod25;
   } part_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      part_type [PARTS-1:0]    part;
   } parts_type;

   typedef struct packed {
      logic              is_valid;
      err_type           err;
      logic [CNT_W-1:0]  count;
      val_type           day;
      val_type           month;
      val_type           year;
      logic [DAY_W-1:0]  max_day;
   } result_type;

   // Residue of (10*r + dig) modulo 25 for r below 25. Since 10*r mod 25 only
   // depends on r mod 5, a five-entry mapping and one subtraction suffice.
   function automatic logic [MOD_W-1:0] mod25_step(logic [MOD_W-1:0] r,
                                                   logic [DIG_W-1:0] dig);
      logic [2:0]       q;
      logic [MOD_W-1:0] rm5;
      logic [MOD_W-1:0] tens;
      logic [MOD_W:0]   t;
      if (r >= 5'd20)      q = 3'd4;
      else if (r >= 5'd15) q = 3'd3;
      else if (r >= 5'd10) q = 3'd2;
      else if (r >= 5'd5)  q = 3'd1;
      else                 q = 3'd0;
      rm5 = r - ({2'b00, q} * 5'd5);
      unique case (rm5[2:0])
         3'd0:    tens = 5'd0;
         3'd1:    tens = 5'd10;
         3'd2:    tens = 5'd20;
         3'd3:    tens = 5'd5;
         3'd4:    tens = 5'd15;
         default: tens = 5'd0;
      endcase
      t = {1'b0, tens} + {2'b00, dig};
      if (t >= MOD_BASE) t = t - MOD_BASE;
      return t[MOD_W-1:0];
   endfunction

   // Month length for a month already known to lie in 1..12.
   function automatic logic [DAY_W-1:0] month_days(logic [DIG_W-1:0] m, logic leap);
      logic [DAY_W-1:0] len;
      len = (m <= 4'd12) ? MONTH_LEN[m] : '0;
      if (m == FEB && leap) len = FEB_LEAP;
      return len;
   endfunction

endpackage

FILE: hdl/dsv_if.sv
// Handshake channels of the date string validator: character input, verdict output.
// Depends on dsv_pkg for field widths and types.
`timescale 1ns / 1ps

interface dsv_req_if;
   logic                          valid;
   logic                          ready;
   logic [dsv_pkg::CHAR_W-1:0]    character;
   logic                          last_char;

   modport source (output valid, character, last_char, input ready);
   modport sink   (input valid, character, last_char, output ready);
endinterface

interface dsv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_valid;
   logic [2:0]                    error_code;
   logic [dsv_pkg::CNT_W-1:0]     part_count;
   logic [dsv_pkg::VAL_W-1:0]     day_value;
   logic [dsv_pkg::VAL_W-1:0]     month_value;
   logic [dsv_pkg::VAL_W-1:0]     year_value;
   logic [dsv_pkg::DAY_W-1:0]     max_day;

   modport source (output valid, is_valid, error_code, part_count, day_value,
                   month_value, year_value, max_day, input ready);
   modport sink   (input valid, is_valid, error_code, part_count, day_value,
                   month_value, year_value, max_day, output ready);
endinterface

FILE: hdl/date_string_validator.sv
// Date string validator: one character per item, one verdict per string.
// Throughput one item per cycle while the part or result register has room;
// after the last character is accepted, the verdict passes the part register, then
// the result register. Synchronous active-high reset clears the parser and both
// valid flags and sets year_min to 1900 and year_max to 2100. Depends on dsv_pkg and dsv_if.
`timescale 1ns / 1ps

module date_string_validator (
   input  logic                             clock,
   input  logic                             reset,
   dsv_req_if.sink                          req_ch,
   dsv_rsp_if.source                        rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dsv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dsv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dsv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   dsv_pkg::val_type      year_min_ff;
   dsv_pkg::val_type      year_max_ff;
   dsv_pkg::csr_idx_type  csr_idx;
   logic                  csr_wr;

   logic                  item_en;
   logic                  fin_valid;
   logic                  fin_pop;
   dsv_pkg::parts_type    fin;
   dsv_pkg::result_type   result_in;
   dsv_pkg::result_type   rsp_ff;
   logic                  rsp_valid_ff;

   // Configuration registers.
   assign pready  = 1'b1;
   assign csr_idx = dsv_pkg::csr_idx_type'(paddr[dsv_pkg::CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_min_ff <= dsv_pkg::YEAR_MIN_RST;
         year_max_ff <= dsv_pkg::YEAR_MAX_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            dsv_pkg::CSR_YEAR_MIN: year_min_ff <= pwdata[dsv_pkg::VAL_W-1:0];
            dsv_pkg::CSR_YEAR_MAX: year_max_ff <= pwdata[dsv_pkg::VAL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         dsv_pkg::CSR_YEAR_MIN: prdata = {1'b0, year_min_ff};
         dsv_pkg::CSR_YEAR_MAX: prdata = {1'b0, year_max_ff};
      endcase
   end

   // The part register drains into the result register whenever that is
   // empty or being read, so the input only stalls when both are full.
   assign fin_pop      = fin_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !fin_valid || fin_pop;
   assign item_en      = req_ch.valid && req_ch.ready;

   dsv_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .character (req_ch.character),
      .last_char (req_ch.last_char),
      .fin_pop   (fin_pop),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   dsv_check u_check (
      .fin      (fin),
      .year_min (year_min_ff),
      .year_max (year_max_ff),
      .result   (result_in)
   );

   always_ff @(posedge clock) begin
      if (fin_pop) begin
         rsp_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.is_valid    = rsp_ff.is_valid;
   assign rsp_ch.error_code  = rsp_ff.err;
   assign rsp_ch.part_count  = rsp_ff.count;
   assign rsp_ch.day_value   = rsp_ff.day;
   assign rsp_ch.month_value = rsp_ff.month;
   assign rsp_ch.year_value  = rsp_ff.year;
   assign rsp_ch.max_day     = rsp_ff.max_day;

endmodule

FILE: hdl/dsv_accum.sv
// Character parser: builds decimal parts, keeps the first three, and hands the
// finished part set of each string to the checker. Depends on dsv_pkg.
`timescale 1ns / 1ps

module dsv_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_en,
   input  logic [dsv_pkg::CHAR_W-1:0]  character,
   input  logic                        last_char,
   input  logic                        fin_pop,
   output logic                        fin_valid,
   output dsv_pkg::parts_type          fin
);

   dsv_pkg::val_type               acc_ff, acc_a;
   logic [dsv_pkg::MOD_W-1:0]      mod_ff, mod_a;
   logic                           open_ff, open_a;
   logic                           ovf_ff, ovf_a;
   logic [dsv_pkg::CNT_W-1:0]      seen_ff, seen_a;
   dsv_pkg::part_type              store_ff [dsv_pkg::PARTS];
   dsv_pkg::part_type              store_in [dsv_pkg::PARTS];
   dsv_pkg::parts_type             fin_ff, fin_in;
   logic                           fin_valid_ff;

   logic                           is_digit;
   logic                           is_sep;
   logic                           close;
   logic                           keep;
   logic [dsv_pkg::DIG_W-1:0]      dig;
   logic [dsv_pkg::VAL_W+3:0]      wide;

   // The low nibble of an ASCII digit is its value.
   assign is_digit = (character >= dsv_pkg::CHAR_ZERO) && (character <= dsv_pkg::CHAR_NINE);
   assign is_sep   = (character == dsv_pkg::CHAR_SLASH) || (character == dsv_pkg::CHAR_DASH)
                  || (character == dsv_pkg::CHAR_DOT);
   assign dig      = character[dsv_pkg::DIG_W-1:0];
   assign wide     = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {{(dsv_pkg::VAL_W){1'b0}}, dig};

   // State after the digit of this item, if any.
   always_comb begin
      acc_a  = acc_ff;
      mod_a  = mod_ff;
      ovf_a  = ovf_ff;
      open_a = open_ff;
      if (is_digit) begin
         open_a = 1'b1;
         if (!ovf_ff) begin
            if (|wide[dsv_pkg::VAL_W+3:dsv_pkg::VAL_W]) begin
               ovf_a = 1'b1;
            end else begin
               acc_a = wide[dsv_pkg::VAL_W-1:0];
               mod_a = dsv_pkg::mod25_step(mod_ff, dig);
            end
         end
      end
   end

   // A separator or the last character closes the part; both never close twice
   // because a separator leaves nothing open.
   assign close  = is_sep || last_char;
   assign keep   = close && open_a && !ovf_a;
   assign seen_a = (keep && (seen_ff != dsv_pkg::CNT_MAX)) ? seen_ff + 4'd1 : seen_ff;

   always_comb begin
      for (int i = 0; i < dsv_pkg::PARTS; i++) begin
         store_in[i] = store_ff[i];
         if (keep && (seen_ff == dsv_pkg::CNT_W'(i))) begin
            store_in[i].value = acc_a;
            store_in[i].mod25 = mod_a;
         end
      end
      fin_in.count = seen_a;
      for (int i = 0; i < dsv_pkg::PARTS; i++) begin
         fin_in.part[i] = store_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         mod_ff  <= '0;
         open_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         seen_ff <= '0;
      end else if (item_en) begin
         if (close) begin
            acc_ff  <= '0;
            mod_ff  <= '0;
            open_ff <= 1'b0;
            ovf_ff  <= 1'b0;
            seen_ff <= last_char ? '0 : seen_a;
         end else begin
            acc_ff  <= acc_a;
            mod_ff  <= mod_a;
            open_ff <= open_a;
            ovf_ff  <= ovf_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_en) begin
         store_ff <= store_in;
      end
      if (item_en && last_char) begin
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (item_en && last_char) begin
         fin_valid_ff <= 1'b1;
      end else if (fin_pop) begin
         fin_valid_ff <= 1'b0;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

FILE: hdl/dsv_check.sv
// Verdict logic: orders the three parts, runs the date checks and forms the result.
// Purely combinational; depends on dsv_pkg.
`timescale 1ns / 1ps

module dsv_check (
   input  dsv_pkg::parts_type  fin,
   input  dsv_pkg::val_type    year_min,
   input  dsv_pkg::val_type    year_max,
   output dsv_pkg::result_type result
);

   logic                       three;
   logic                       year_first;
   dsv_pkg::val_type           d, m, y;
   logic [dsv_pkg::MOD_W-1:0]  y_mod;
   logic                       month_ok;
   logic                       leap;
   logic [dsv_pkg::DAY_W-1:0]  mx;

   assign three      = (fin.count == dsv_pkg::CNT_DATE);
   assign year_first = (fin.part[0].value > dsv_pkg::DAY_LIMIT);
   assign d          = year_first ? fin.part[2].value : fin.part[0].value;
   assign m          = fin.part[1].value;
   assign y          = year_first ? fin.part[0].value : fin.part[2].value;
   assign y_mod      = year_first ? fin.part[0].mod25 : fin.part[2].mod25;
   assign month_ok   = (m >= 31'd1) && (m <= dsv_pkg::MONTH_MAX);

   // Divisible by 100 means divisible by 4 and by 25; by 400 means by 16 and 25.
   assign leap = ((y[1:0] == 2'b00) && (y_mod != '0)) || ((y[3:0] == 4'b0000) && (y_mod == '0));
   assign mx   = month_ok ? dsv_pkg::month_days(m[dsv_pkg::DIG_W-1:0], leap) : '0;

   always_comb begin
      result.count   = fin.count;
      result.day     = '0;
      result.month   = '0;
      result.year    = '0;
      result.max_day = '0;
      result.err     = dsv_pkg::ERR_NONE;
      if (!three) begin
         result.err = dsv_pkg::ERR_PART_COUNT;
      end else begin
         result.day     = d;
         result.month   = m;
         result.year    = y;
         result.max_day = mx;
         priority if (!month_ok) begin
            result.err = dsv_pkg::ERR_MONTH;
         end else if ((d == '0) || (d > {26'd0, mx})) begin
            result.err = dsv_pkg::ERR_DAY;
         end else if ((y < year_min) || (y > year_max)) begin
            result.err = dsv_pkg::ERR_YEAR;
         end else begin
            result.err = dsv_pkg::ERR_NONE;
         end
      end
      result.is_valid = (result.err == dsv_pkg::ERR_NONE);
   end

endmodule

FILE: hdl/dsv_checker.sv
// Port-level checks on the verdict channel of the date string validator, bound
// to the top level. Depends on dsv_pkg and date_string_validator_assert.svh.
`timescale 1ns / 1ps
`include "date_string_validator_assert.svh"

module dsv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        is_valid,
   input logic [2:0]                  error_code,
   input logic [dsv_pkg::CNT_W-1:0]   part_count,
   input logic [dsv_pkg::VAL_W-1:0]   day_value,
   input logic [dsv_pkg::VAL_W-1:0]   month_value,
   input logic [dsv_pkg::VAL_W-1:0]   year_value,
   input logic [dsv_pkg::DAY_W-1:0]   max_day
);

   `DSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(error_code) && $stable(day_value) && $stable(year_value), "verdict changed while stalled")

   `DSV_ASSERT_NOW(a_valid_code, clock, reset, rsp_valid, (is_valid == (error_code == dsv_pkg::ERR_NONE)) && (error_code <= dsv_pkg::ERR_YEAR), "is_valid disagrees with error_code")

   `DSV_ASSERT_NOW(a_count_zero, clock, reset, rsp_valid && (error_code == dsv_pkg::ERR_PART_COUNT), (part_count != dsv_pkg::CNT_DATE) && (day_value == '0) && (month_value == '0) && (year_value == '0) && (max_day == '0), "part count error with nonzero fields")

   `DSV_ASSERT_NOW(a_valid_date, clock, reset, rsp_valid && is_valid, (part_count == dsv_pkg::CNT_DATE) && (month_value >= 31'd1) && (month_value <= dsv_pkg::MONTH_MAX) && (day_value >= 31'd1) && (day_value <= {26'd0, max_day}), "valid verdict on impossible date")

endmodule

bind date_string_validator dsv_checker u_dsv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .is_valid    (rsp_ch.is_valid),
   .error_code  (rsp_ch.error_code),
   .part_count  (rsp_ch.part_count),
   .day_value   (rsp_ch.day_value),
   .month_value (rsp_ch.month_value),
   .year_value  (rsp_ch.year_value),
   .max_day     (rsp_ch.max_day)
);

FILE: tb/date_string_validator_test.sv
// Self-checking bench for date_string_validator: streams date strings one character
// per item and checks every verdict against a predictor kept in a scoreboard class.
// Depends on dsv_pkg, the dsv_req_if/dsv_rsp_if channels and the block itself.
`timescale 1ns / 1ps

module date_string_validator_test;
   import dsv_pkg::*;

   localparam int      CLOCK_HALF       = 10;
   localparam int      RANDOM_ITEMS     = 1900;
   localparam int      PHASES           = 7;
   localparam int      WATCHDOG_LIMIT   = 2000;
   localparam int      SHOWN_MISMATCHES = 10;
   localparam val_type YEAR_TOP         = 31'h7FFF_FFFF;

   class date_verdict_board;
      val_type          year_lo;
      val_type          year_hi;
      val_type          acc;
      logic             digits_open;
      logic             too_big;
      logic [CNT_W-1:0] parts;
      val_type          kept [PARTS];
      result_type       verdicts_due [$];
      int               mismatches;
      int               verdicts_seen;
      int               err_tally [5];

      function new();
         year_lo = YEAR_MIN_RST;
         year_hi = YEAR_MAX_RST;
         acc = '0;
         digits_open = 1'b0;
         too_big = 1'b0;
         parts = '0;
         foreach (kept[i]) kept[i] = '0;
         mismatches = 0;
         verdicts_seen = 0;
         foreach (err_tally[i]) err_tally[i] = 0;
      endfunction

      static function int unsigned month_length(longint unsigned m, longint unsigned y);
         logic leap_year;
         leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function void set_year_bound(csr_idx_type idx, val_type v);
         if (idx == CSR_YEAR_MIN) year_lo = v;
         else year_hi = v;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES) $display("[%0t] mismatch: %s", $time, what);
      endfunction

      // An oversized part is dropped here without being counted or stored.
      function void close_part();
         if (digits_open && !too_big) begin
            if (parts < PARTS) kept[parts] = acc;
            if (parts != CNT_MAX) parts++;
         end
         acc = '0;
         digits_open = 1'b0;
         too_big = 1'b0;
      endfunction

      function void take_char(logic [CHAR_W-1:0] ch, logic last);
         longint unsigned grown;
         longint unsigned d, m, y, mlen;
         result_type      want;
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            if (!too_big) begin
               grown = longint'(acc) * 10 + (ch - CHAR_ZERO);
               if (grown > YEAR_TOP) too_big = 1'b1;
               else acc = grown[VAL_W-1:0];
            end
            digits_open = 1'b1;
         end else if (ch == CHAR_SLASH || ch == CHAR_DASH || ch == CHAR_DOT) begin
            close_part();
         end
         if (!last) return;
         close_part();
         d = 0;
         m = 0;
         y = 0;
         mlen = 0;
         want.err = ERR_NONE;
         if (parts != CNT_DATE) begin
            want.err = ERR_PART_COUNT;
         end else begin
            // A first part too large to be a day means year-month-day order.
            if (kept[0] > DAY_LIMIT) begin
               y = kept[0];
               m = kept[1];
               d = kept[2];
            end else begin
               d = kept[0];
               m = kept[1];
               y = kept[2];
            end
            if (m < 1 || m > MONTH_MAX) begin
               want.err = ERR_MONTH;
            end else begin
               mlen = month_length(m, y);
               if (d < 1 || d > mlen) want.err = ERR_DAY;
               else if (y < year_lo || y > year_hi) want.err = ERR_YEAR;
            end
         end
         want.is_valid = (want.err == ERR_NONE);
         want.count = parts;
         want.day = d[VAL_W-1:0];
         want.month = m[VAL_W-1:0];
         want.year = y[VAL_W-1:0];
         want.max_day = mlen[DAY_W-1:0];
         verdicts_due.insert(verdicts_due.size(), want);
         err_tally[want.err]++;
         parts = '0;
      endfunction

      function void check_verdict(result_type got);
         result_type want;
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            flag($sformatf("verdict with none expected: valid=%0d err=%0d parts=%0d",
                           got.is_valid, got.err, got.count));
            return;
         end
         want = verdicts_due.pop_front();
         if (got.is_valid !== want.is_valid || got.err !== want.err ||
             got.count !== want.count || got.day !== want.day ||
             got.month !== want.month || got.year !== want.year ||
             got.max_day !== want.max_day)
            flag({$sformatf("expected valid=%0d err=%0d parts=%0d d/m/y=%0d/%0d/%0d max=%0d",
                            want.is_valid, want.err, want.count, want.day, want.month,
                            want.year, want.max_day),
                  $sformatf(", got valid=%0d err=%0d parts=%0d d/m/y=%0d/%0d/%0d max=%0d",
                            got.is_valid, got.err, got.count, got.day, got.month,
                            got.year, got.max_day)});
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   dsv_req_if req_ch();
   dsv_rsp_if rsp_ch();

   date_string_validator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   date_verdict_board board = new();
   logic [CHAR_W-1:0] text [$];
   int idle_pct     = 10;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int real_items   = 0;
   int texts_sent   = 0;

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // Result side back-pressure: random bursts of stalls, never back to back.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else if (rsp_ch.ready && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 18);
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // Results are checked before the same edge's input is noted; a verdict can never
   // come from a character accepted at the same edge.
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.is_valid = rsp_ch.is_valid;
            got.err = err_type'(rsp_ch.error_code);
            got.count = rsp_ch.part_count;
            got.day = rsp_ch.day_value;
            got.month = rsp_ch.month_value;
            got.year = rsp_ch.year_value;
            got.max_day = rsp_ch.max_day;
            board.check_verdict(got);
         end
         if (req_ch.valid && req_ch.ready)
            board.take_char(req_ch.character, req_ch.last_char);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
   end

   function automatic void add_char(logic [CHAR_W-1:0] c);
      text.insert(text.size(), c);
   endfunction

   function automatic void put_string(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   function automatic void put_number(longint unsigned v, int zeros);
      logic [CHAR_W-1:0] digits [$];
      repeat (zeros) add_char(CHAR_ZERO);
      do begin
         digits.push_front(CHAR_ZERO + CHAR_W'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) add_char(digits[i]);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_sep();
      case ($urandom_range(0, 2))
         0:       return CHAR_SLASH;
         1:       return CHAR_DASH;
         default: return CHAR_DOT;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_filler();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255));
      while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SLASH || c == CHAR_DASH ||
             c == CHAR_DOT);
      return c;
   endfunction

   function automatic longint unsigned pick_year();
      longint unsigned lo, hi;
      lo = board.year_lo;
      hi = board.year_hi;
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         2: return (lo == 0) ? 0 : lo - 1;
         3: return (hi == YEAR_TOP) ? hi : hi + 1;
         4: case ($urandom_range(0, 5))
               0:       return 1900;
               1:       return 2000;
               2:       return 2100;
               3:       return 2400;
               4:       return 2024;
               default: return 2023;
            endcase
         5: return $urandom_range(0, 31);
         6: return $urandom_range(32, 9999);
         default: return (lo <= hi) ? lo + $urandom % (hi - lo + 1) : $urandom_range(1000, 3000);
      endcase
   endfunction

   // Mostly well-formed dates with random content; the rest are oversized parts,
   // long part lists, short part lists and raw byte noise.
   function automatic void make_text();
      longint unsigned d, m, y;
      longint unsigned field [3];
      int              n, k, r;
      text.delete();
      r = $urandom_range(0, 99);
      if (r < 65) begin
         y = pick_year();
         if ($urandom_range(0, 4) != 0) begin
            m = $urandom_range(1, 12);
         end else begin
            case ($urandom_range(0, 3))
               0:       m = 0;
               1:       m = 13;
               2:       m = $urandom_range(14, 99);
               default: m = $urandom & YEAR_TOP;
            endcase
         end
         k = date_verdict_board::month_length(m, y);
         if (k != 0 && $urandom_range(0, 9) < 7) begin
            d = $urandom_range(1, k);
         end else begin
            case ($urandom_range(0, 5))
               0:       d = 0;
               1:       d = k;
               2:       d = k + 1;
               3:       d = 31;
               4:       d = 32;
               default: d = $urandom_range(0, 99);
            endcase
         end
         if (y > 31 && $urandom_range(0, 1) == 1) begin
            field[0] = y;
            field[1] = m;
            field[2] = d;
         end else begin
            field[0] = d;
            field[1] = m;
            field[2] = y;
         end
         if ($urandom_range(0, 19) == 0) add_char(pick_sep());
         for (int i = 0; i < 3; i++) begin
            if (i != 0) begin
               add_char(pick_sep());
               if ($urandom_range(0, 19) == 0) add_char(pick_sep());
            end
            put_number(field[i], ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
         end
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) text.insert($urandom_range(0, text.size()), pick_filler());
         case ($urandom_range(0, 19))
            0, 1:    add_char(pick_sep());
            2:       add_char(pick_filler());
            default: ;
         endcase
      end else if (r < 73) begin
         n = $urandom_range(2, 4);
         k = $urandom_range(0, n - 1);
         for (int i = 0; i < n; i++) begin
            if (i != 0) add_char(pick_sep());
            if (i != k) begin
               put_number($urandom_range(1, 2100), 0);
            end else begin
               case ($urandom_range(0, 4))
                  0: put_string("2147483648");
                  1: put_string("2147483647");
                  2: put_string("0002147483648");
                  3: begin
                     add_char(CHAR_ZERO + CHAR_W'($urandom_range(1, 9)));
                     repeat ($urandom_range(10, 13))
                        add_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
                  end
                  default: put_string("99999999999");
               endcase
            end
         end
      end else if (r < 80) begin
         n = $urandom_range(4, 20);
         for (int i = 0; i < n; i++) begin
            if (i != 0) add_char(pick_sep());
            put_number($urandom_range(0, 2100), 0);
         end
      end else if (r < 88) begin
         n = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            if (i != 0) add_char(pick_sep());
            put_number($urandom_range(0, 2100), 0);
         end
         if (n == 0) add_char(($urandom_range(0, 1) == 1) ? pick_filler() : pick_sep());
      end else begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 2) == 0) add_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            else if ($urandom_range(0, 2) == 0) add_char(pick_sep());
            else add_char(CHAR_W'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) begin
         if ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         req_ch.valid = 1'b1;
         req_ch.character = text[i];
         req_ch.last_char = (i == text.size() - 1);
         do @(posedge clock); while (!req_ch.ready);
         if ((text[i] >= CHAR_ZERO && text[i] <= CHAR_NINE) || text[i] == CHAR_SLASH ||
             text[i] == CHAR_DASH || text[i] == CHAR_DOT || req_ch.last_char)
            real_items++;
         @(negedge clock);
      end
      texts_sent++;
   endtask

   // Holds the input until every verdict has come back, then lets the pipeline drain.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, val_type value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = {1'($urandom_range(0, 1)), value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      board.set_year_bound(idx, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_read_check(csr_idx_type idx, val_type want);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {1'b0, want})
         board.flag($sformatf("register %s reads %0d, written %0d", idx.name(), prdata, want));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   initial begin
      val_type lo_tab [PHASES];
      val_type hi_tab [PHASES];
      int      per_phase;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.character = '0;
      req_ch.last_char = 1'b0;
      // Phase 0 runs on the reset bounds; later phases cover the extremes,
      // a single-year window, an inverted window and a random window.
      lo_tab = '{YEAR_MIN_RST, 31'd0, 31'd2000, 31'd2100, YEAR_TOP, 31'd0, 31'd0};
      hi_tab = '{YEAR_MAX_RST, YEAR_TOP, 31'd2000, 31'd1900, YEAR_TOP, 31'd0, 31'd0};
      lo_tab[PHASES-1] = VAL_W'($urandom_range(1000, 2500));
      hi_tab[PHASES-1] = lo_tab[PHASES-1] + VAL_W'($urandom_range(0, 500));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      text.delete();
      add_char(8'h00);
      send_text();
      text.delete();
      add_char(8'hFF);
      put_string("29.2.2000");
      send_text();
      text.delete();
      put_string("1/13/9");
      send_text();
      text.delete();
      put_string("2023-2-29");
      send_text();

      real_items = 0;
      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            settle();
            csr_write(CSR_YEAR_MIN, lo_tab[ph]);
            csr_write(CSR_YEAR_MAX, hi_tab[ph]);
            csr_read_check(CSR_YEAR_MIN, lo_tab[ph]);
            csr_read_check(CSR_YEAR_MAX, hi_tab[ph]);
         end
         idle_pct = (ph == 2 || ph == PHASES - 1) ? 0 : ((ph % 2 == 0) ? 8 : 25);
         while (real_items < per_phase * (ph + 1)) begin
            make_text();
            send_text();
         end
      end

      req_ch.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d strings, %0d verdicts, %0d year windows incl. inverted and extreme.",
               texts_sent, board.verdicts_seen, PHASES);
      $display("Verdict mix: %0d ok, %0d count, %0d month, %0d day, %0d year; %0d mismatches.",
               board.err_tally[ERR_NONE], board.err_tally[ERR_PART_COUNT],
               board.err_tally[ERR_MONTH], board.err_tally[ERR_DAY],
               board.err_tally[ERR_YEAR], board.mismatches);
      if (board.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dsv_pkg.sv
hdl/dsv_if.sv
hdl/dsv_accum.sv
hdl/dsv_check.sv
hdl/date_string_validator.sv
hdl/dsv_checker.sv
tb/date_string_validator_test.sv
